[rtl/rme_pkg.sv]
// ============================================================================
// rme_pkg
// Shared types and constants for the modular exponentiation block.
// ============================================================================
package rme_pkg;

    localparam int RME_WIDTH = 32;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_RED_END,
        ST_CHECK,
        ST_MACC,
        ST_MACC_END,
        ST_MSQ,
        ST_MSQ_END,
        ST_DONE
    } state_t;

    // Which product the shared multiplier is forming
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_ACC,
        SEL_SQ
    } mul_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     mul_step;
        logic     commit;
        logic     exp_shift;
        logic     out_write;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic mul_last;
        logic exp_bit;
        logic exp_last;
        logic mod_small;
        logic out_full;
    } status_t;

endpackage

[rtl/rme_regs.sv]
// ============================================================================
// rme_regs
// APB register file: public exponent, private exponent and modulus.
// ============================================================================
module rme_regs #(
    parameter int WIDTH  = 32,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [WIDTH-1:0]  pub_exp,
    output logic [WIDTH-1:0]  priv_exp,
    output logic [WIDTH-1:0]  modulus
);
    import rme_pkg::*;

    localparam int ASH = (DATA_W > 32) ? 3 : 2;
    localparam int IDX_W = ADDR_W - ASH;
    localparam logic [IDX_W-1:0] IDX_PUB  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_PRIV = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_MOD  = IDX_W'(2);

    logic [WIDTH-1:0] pub_reg;
    logic [WIDTH-1:0] priv_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:ASH];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pub_reg  <= '0;
            priv_reg <= '0;
            mod_reg  <= WIDTH'(2);
        end else if (wr_en) begin
            unique case (idx)
                IDX_PUB:  pub_reg  <= pwdata[WIDTH-1:0];
                IDX_PRIV: priv_reg <= pwdata[WIDTH-1:0];
                IDX_MOD:  mod_reg  <= pwdata[WIDTH-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            IDX_PUB:  prdata = DATA_W'(pub_reg);
            IDX_PRIV: prdata = DATA_W'(priv_reg);
            IDX_MOD:  prdata = DATA_W'(mod_reg);
            default:  prdata = '0;
        endcase
    end

    assign pub_exp  = pub_reg;
    assign priv_exp = priv_reg;
    assign modulus  = mod_reg;

endmodule

[rtl/rme_ctrl.sv]
// ============================================================================
// rme_ctrl
// Sequencer for square-and-multiply: reduce, then per exponent bit
// an optional accumulate product and a squaring product (skipped on the last bit).
// ============================================================================
module rme_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rme_pkg::status_t sts,
    output rme_pkg::cmd_t    cmd
);
    import rme_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = sts.mod_small ? ST_DONE : ST_RED;
                end
            end
            ST_RED: begin
                if (sts.mul_last) state_next = ST_RED_END;
            end
            ST_RED_END: state_next = ST_CHECK;
            ST_CHECK: begin
                if (sts.exp_bit)       state_next = ST_MACC;
                else if (sts.exp_last) state_next = ST_DONE;
                else                   state_next = ST_MSQ;
            end
            ST_MACC: begin
                if (sts.mul_last) state_next = ST_MACC_END;
            end
            ST_MACC_END: state_next = sts.exp_last ? ST_DONE : ST_MSQ;
            ST_MSQ: begin
                if (sts.mul_last) state_next = ST_MSQ_END;
            end
            ST_MSQ_END: state_next = ST_CHECK;
            ST_DONE: begin
                if (!sts.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.mul_sel = SEL_RED;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load      = 1'b1;
                    cmd.mul_start = !sts.mod_small;
                    cmd.mul_sel   = SEL_RED;
                end
            end
            ST_RED, ST_MACC, ST_MSQ: cmd.mul_step = 1'b1;
            ST_RED_END: cmd.commit = 1'b1;
            ST_CHECK: begin
                if (sts.exp_bit) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = SEL_ACC;
                end else if (!sts.exp_last) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = SEL_SQ;
                end
            end
            ST_MACC_END: begin
                cmd.commit = 1'b1;
                if (!sts.exp_last) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = SEL_SQ;
                end
            end
            ST_MSQ_END: begin
                cmd.commit    = 1'b1;
                cmd.exp_shift = 1'b1;
            end
            ST_DONE: cmd.out_write = !sts.out_full;
            default: ;
        endcase
    end

endmodule

[rtl/rme_dp.sv]
// ============================================================================
// rme_dp
// Datapath: operand and exponent registers, shared bit-serial modular
// multiplier (also used for the initial reduction) and output register.
// ============================================================================
module rme_dp #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             func,
    input  logic [WIDTH-1:0] operand,
    input  logic [WIDTH-1:0] pub_exp,
    input  logic [WIDTH-1:0] priv_exp,
    input  logic [WIDTH-1:0] modulus,
    input  rme_pkg::cmd_t    cmd,
    output rme_pkg::status_t sts,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] result
);
    import rme_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic [WIDTH-1:0] operand_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] sq_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] bitcnt_reg;
    mul_sel_t         sel_reg;
    logic [WIDTH-1:0] result_reg;
    logic             out_valid_reg;

    logic [WIDTH-1:0] addend;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m_ext;
    logic [WIDTH+1:0] m2_ext;
    logic [WIDTH-1:0] r_next;

    // 2r + addend stays below 3m; subtract m or 2m to bring it back under m
    always_comb begin
        case (sel_reg)
            SEL_RED: addend = WIDTH'(b_reg[WIDTH-1]);
            SEL_ACC: addend = b_reg[WIDTH-1] ? acc_reg : '0;
            default: addend = b_reg[WIDTH-1] ? sq_reg : '0;
        endcase
        m_ext  = (WIDTH+2)'(modulus);
        m2_ext = {1'b0, modulus, 1'b0};
        sum    = {1'b0, r_reg, 1'b0} + (WIDTH+2)'(addend);
        if (sum >= m2_ext)     r_next = WIDTH'(sum - m2_ext);
        else if (sum >= m_ext) r_next = WIDTH'(sum - m_ext);
        else                   r_next = sum[WIDTH-1:0];
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            operand_reg <= operand;
            exp_reg     <= func ? priv_exp : pub_exp;
            acc_reg     <= WIDTH'(1);
            bitcnt_reg  <= '0;
        end else if (cmd.exp_shift) begin
            exp_reg    <= exp_reg >> 1;
            bitcnt_reg <= bitcnt_reg + CNT_W'(1);
        end
        if (cmd.mul_start) begin
            r_reg   <= '0;
            cnt_reg <= '0;
            sel_reg <= cmd.mul_sel;
            b_reg   <= (cmd.mul_sel == SEL_RED) ? (cmd.load ? operand : operand_reg)
                                                : sq_reg;
        end else if (cmd.mul_step) begin
            r_reg   <= r_next;
            b_reg   <= b_reg << 1;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.commit) begin
            if (sel_reg == SEL_ACC) acc_reg <= r_reg;
            else                    sq_reg  <= r_reg;
        end
        if (cmd.out_write) begin
            result_reg <= sts.mod_small ? '0 : acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_write) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.mul_last  = (cnt_reg == CNT_LAST);
    assign sts.exp_bit   = exp_reg[0];
    assign sts.exp_last  = (bitcnt_reg == CNT_LAST);
    assign sts.mod_small = (modulus[WIDTH-1:1] == '0);
    assign sts.out_full  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

[rtl/rsa_modular_exponentiation.sv]
// ============================================================================
// rsa_modular_exponentiation
// Modular exponentiation by right-to-left square-and-multiply.
// ============================================================================
// Configure public_exponent (0x0), private_exponent (0x4) and modulus (0x8)
// over the APB port while no item is in work. Each input item carries func
// (0 encrypt with the public exponent, 1 decrypt with the private exponent)
// and operand; one result item, operand^exp mod modulus, comes back for each.
// A zero exponent gives 1; a modulus below two gives 0 with no multiply run.
// One item at a time, paced by the shared bit-serial modular multiplier:
// reduce the operand, then per exponent bit spend a check state, a multiply
// on a set bit and a squaring (skipped on the last bit). in_ready rises with
// out_valid, so the next item is taken at the earliest once the previous result is valid.
// Reset (rst_n) clears the sequencer and output valid flag and restores
// exponents 0, modulus 2. A result held for out_ready does not block the
// next item: it is accepted and computed, then holds until the register frees.
// ============================================================================
module rsa_modular_exponentiation #(
    parameter int WIDTH = rme_pkg::RME_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [((WIDTH > 32) ? 5 : 4)-1:0]   paddr,
    input  logic [((WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [WIDTH-1:0]                    operand,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [WIDTH-1:0]                    result
);
    import rme_pkg::*;

    localparam int DATA_W = (WIDTH > 32) ? 64 : 32;
    localparam int ADDR_W = (WIDTH > 32) ? 5 : 4;

    logic [WIDTH-1:0] pub_exp;
    logic [WIDTH-1:0] priv_exp;
    logic [WIDTH-1:0] modulus;
    cmd_t             cmd;
    status_t          sts;

    // Configuration registers
    rme_regs #(
        .WIDTH  (WIDTH),
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pub_exp  (pub_exp),
        .priv_exp (priv_exp),
        .modulus  (modulus)
    );

    // Sequencer: issue reduce, multiply and square steps
    rme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and output register
    rme_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .func      (func),
        .operand   (operand),
        .pub_exp   (pub_exp),
        .priv_exp  (priv_exp),
        .modulus   (modulus),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

endmodule

[rtl/rme_chk.sv]
// ============================================================================
// rme_chk
// Port-level checks for the modular exponentiation block.
// ============================================================================
module rme_chk #(
    parameter int WIDTH = 32
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] result
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("stalled result item dropped or changed");

    // Drop ready after accepting an item: one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in work");

    // A result never appears in the cycle right after an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result item appeared too early");

endmodule

bind rsa_modular_exponentiation rme_chk #(
    .WIDTH (WIDTH)
) u_rme_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);
